/* hw/rtl/float_integer_power_top_assert.svh */
// ----------------------------------------------------------------------------
// float_integer_power_top_assert.svh
// Assertion macros shared by the checker of the integer power block.
// ----------------------------------------------------------------------------
`ifndef FLOAT_INTEGER_POWER_TOP_ASSERT_SVH
`define FLOAT_INTEGER_POWER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset.
`define FIP_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fip assertion failed");

// Next-cycle implication, sampled on the rising clock, idle during reset.
`define FIP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fip assertion failed");

`endif

/* hw/rtl/fip_pkg.sv */
// ----------------------------------------------------------------------------
// fip_pkg
// Types, constants and helpers of the floating-point integer power block.
// ----------------------------------------------------------------------------
package fip_pkg;

  localparam int unsigned ExponentLimit = 2047;
  localparam int unsigned ExpW = 12;

  localparam logic [63:0] BitsPosInf  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] BitsNegInf  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] BitsOne     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] BitsZero    = 64'h0000_0000_0000_0000;
  localparam logic [63:0] BitsDfltNan = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QuietBit    = 64'h0008_0000_0000_0000;

  typedef enum logic {
    OP_MUL,
    OP_RCP
  } fip_op_e;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    fip_op_e op;
  } fip_req_t;

  // Effective biased exponent: subnormals use exponent one.
  function automatic logic [10:0] eff_exp(input logic [63:0] x);
    eff_exp = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
  endfunction

  // Significand with the hidden bit made explicit.
  function automatic logic [52:0] full_mant(input logic [63:0] x);
    full_mant = {(x[62:52] != 11'd0), x[51:0]};
  endfunction

  function automatic logic is_nan(input logic [63:0] x);
    is_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(input logic [63:0] x);
    is_inf = (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
  endfunction

  function automatic logic is_zero(input logic [63:0] x);
    is_zero = (x[62:0] == 63'd0);
  endfunction

endpackage

/* hw/rtl/fip_fpu.sv */
// ----------------------------------------------------------------------------
// fip_fpu
// Multi-cycle double unit: rounded multiply and correctly rounded reciprocal.
// ----------------------------------------------------------------------------
module fip_fpu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fip_pkg::fip_req_t req_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      b_i,
  output logic             done_o,
  output logic [63:0]      res_o
);
  import fip_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_NRM  = 3'd4;
  localparam logic [2:0] S_RND  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [105:0]        p_q, p_d;
  logic signed [13:0]  e_q, e_d;
  logic                s_q, s_d;
  logic [52:0]         opa_q, opa_d, opb_q, opb_d;
  logic [53:0]         r_q, r_d;
  logic [53:0]         qt_q, qt_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [63:0]         res_q, res_d;
  logic                done_q, done_d;

  logic [26:0]  mx, my;
  logic [53:0]  pp;
  logic [105:0] pp_ext;
  logic         ge;
  logic [53:0]  rs;
  logic [52:0]  rmant;
  logic [53:0]  m2;
  logic         rinc;
  logic signed [13:0] ef;

  // Shared 27x27 partial-product multiplier.
  assign mx = cnt_q[1] ? {1'b0, opa_q[52:27]} : opa_q[26:0];
  assign my = cnt_q[0] ? {1'b0, opb_q[52:27]} : opb_q[26:0];
  assign pp = mx * my;

  always_comb begin
    unique case ({cnt_q[1], cnt_q[0]})
      2'b00:   pp_ext = {52'd0, pp};
      2'b11:   pp_ext = {pp, 52'd0} << 2;
      default: pp_ext = {25'd0, pp, 27'd0};
    endcase
  end

  assign ge = (r_q >= {1'b0, opa_q});
  assign rs = ge ? (r_q - {1'b0, opa_q}) : r_q;

  assign rmant = p_q[104:52];
  assign rinc  = p_q[51] & ((|p_q[50:0]) | rmant[0]);
  assign m2    = {1'b0, rmant} + {53'd0, rinc};
  assign ef    = m2[53] ? (e_q + 14'sd1) : e_q;

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    e_d     = e_q;
    s_d     = s_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    r_d     = r_q;
    qt_d    = qt_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == OP_MUL) begin
            s_d = a_i[63] ^ b_i[63];
            if (is_nan(a_i)) begin
              res_d = a_i | QuietBit; done_d = 1'b1;
            end else if (is_nan(b_i)) begin
              res_d = b_i | QuietBit; done_d = 1'b1;
            end else if ((is_inf(a_i) && is_zero(b_i)) || (is_zero(a_i) && is_inf(b_i))) begin
              res_d = BitsDfltNan; done_d = 1'b1;
            end else if (is_inf(a_i) || is_inf(b_i)) begin
              res_d = {a_i[63] ^ b_i[63], BitsPosInf[62:0]}; done_d = 1'b1;
            end else if (is_zero(a_i) || is_zero(b_i)) begin
              res_d = {a_i[63] ^ b_i[63], 63'd0}; done_d = 1'b1;
            end else begin
              opa_d   = full_mant(a_i);
              opb_d   = full_mant(b_i);
              e_d     = $signed({3'd0, eff_exp(a_i)}) + $signed({3'd0, eff_exp(b_i)})
                        - 14'sd1023;
              p_d     = '0;
              cnt_d   = '0;
              state_d = S_MUL;
            end
          end else begin
            s_d = a_i[63];
            if (is_nan(a_i)) begin
              res_d = a_i | QuietBit; done_d = 1'b1;
            end else if (is_inf(a_i)) begin
              res_d = {a_i[63], 63'd0}; done_d = 1'b1;
            end else if (is_zero(a_i)) begin
              res_d = {a_i[63], BitsPosInf[62:0]}; done_d = 1'b1;
            end else begin
              opa_d   = full_mant(a_i);
              e_d     = $signed({3'd0, eff_exp(a_i)});
              state_d = S_PRE;
            end
          end
        end
      end
      S_MUL: begin
        p_d   = p_q + pp_ext;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = S_NRM;
        end
      end
      S_PRE: begin
        // Bring a subnormal divisor to the normal form first.
        if (opa_q[52]) begin
          r_d     = {2'b01, 52'd0};
          qt_d    = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          opa_d = {opa_q[51:0], 1'b0};
          e_d   = e_q - 14'sd1;
        end
      end
      S_DIV: begin
        r_d   = {rs[52:0], 1'b0};
        qt_d  = {qt_q[52:0], ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd54) begin
          p_d     = {1'b0, qt_q[53:0], ge, 49'd0, (rs != 54'd0)};
          e_d     = 14'sd2046 - e_q;
          state_d = S_NRM;
        end
      end
      S_NRM: begin
        // Bit zero collects everything shifted out to the right.
        if (e_q < -14'sd110) begin
          p_d = {105'd0, (p_q != 106'd0)};
          e_d = 14'sd1;
        end else if (p_q[105] || (e_q < 14'sd1)) begin
          p_d = {1'b0, p_q[105:2], p_q[1] | p_q[0]};
          e_d = e_q + 14'sd1;
        end else if (!p_q[104] && (e_q > 14'sd1)) begin
          p_d = {p_q[104:0], 1'b0};
          e_d = e_q - 14'sd1;
        end else begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (!m2[53] && !m2[52]) begin
          res_d = {s_q, 11'd0, m2[51:0]};
        end else if (ef >= 14'sd2047) begin
          res_d = {s_q, BitsPosInf[62:0]};
        end else if (m2[53]) begin
          res_d = {s_q, ef[10:0], m2[52:1]};
        end else begin
          res_d = {s_q, ef[10:0], m2[51:0]};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    e_q   <= e_d;
    s_q   <= s_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    r_q   <= r_d;
    qt_q  <= qt_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* hw/rtl/float_integer_power_top.sv */
// ----------------------------------------------------------------------------
// float_integer_power_top
// Raises a double base to a signed integer power by repeated rounded products.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | base_bits_i, exponent_i
//   out     | output    | out_valid_o/out_ready_i| result_bits_o
//
// A request with a zero base or a zero exponent skips the arithmetic unit:
// its result goes to the output register once that is free, and the block
// is ready again then. Otherwise each of the |exponent| products (at most
// 2047) runs through the shared unit (four 27x27 partial products,
// normalize, round), and a negative exponent adds the bit-serial reciprocal.
// The block takes no new request until the current one is finished; a
// finished result waits in the output register while the next request runs.
// Reset is asynchronous and active low and clears only the control state.
module float_integer_power_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] base_bits_i,
  input  logic signed [11:0] exponent_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_bits_o
);
  import fip_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_MUL  = 2'd1;
  localparam logic [1:0] T_RCP  = 2'd2;
  localparam logic [1:0] T_FIN  = 2'd3;

  localparam logic [16:0] LimitV = 17'(ExponentLimit);

  logic [1:0]      state_q, state_d;
  fip_req_t        req_q, req_d;
  logic [63:0]     base_q, base_d;
  logic [63:0]     acc_q, acc_d;
  logic [ExpW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic [63:0]     res_q, res_d;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     out_data_q, out_data_d;

  logic            fpu_done;
  logic [63:0]     fpu_res;
  logic [ExpW-1:0] mag_raw, mag;

  // Magnitude of the exponent; the most negative code gives 2048, clamped to 2047.
  assign mag_raw = exponent_i[11] ? (~exponent_i + 12'd1) : exponent_i;
  assign mag     = ({5'd0, mag_raw} > LimitV) ? LimitV[ExpW-1:0] : mag_raw;

  fip_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .a_i    (acc_q),
    .b_i    (base_q),
    .done_o (fpu_done),
    .res_o  (fpu_res)
  );

  always_comb begin
    state_d     = state_q;
    req_d       = '{start: 1'b0, op: OP_MUL};
    base_d      = base_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      T_IDLE: begin
        if (in_valid_i) begin
          base_d = base_bits_i;
          neg_d  = exponent_i[11];
          cnt_d  = mag;
          acc_d  = BitsOne;
          if (is_zero(base_bits_i)) begin
            // Zero base: infinity, one or zero depending on the exponent.
            if (exponent_i[11]) begin
              res_d = BitsPosInf;
            end else if (mag == '0) begin
              res_d = BitsOne;
            end else begin
              res_d = BitsZero;
            end
            state_d = T_FIN;
          end else if (mag == '0) begin
            res_d   = BitsOne;
            state_d = T_FIN;
          end else begin
            req_d   = '{start: 1'b1, op: OP_MUL};
            state_d = T_MUL;
          end
        end
      end
      T_MUL: begin
        if (fpu_done) begin
          acc_d = fpu_res;
          cnt_d = cnt_q - {{(ExpW-1){1'b0}}, 1'b1};
          if (cnt_q == {{(ExpW-1){1'b0}}, 1'b1}) begin
            if (!neg_q) begin
              res_d   = fpu_res;
              state_d = T_FIN;
            end else if (is_zero(fpu_res)) begin
              // The reciprocal of a signed zero keeps its sign.
              res_d   = fpu_res[63] ? BitsNegInf : BitsPosInf;
              state_d = T_FIN;
            end else begin
              req_d   = '{start: 1'b1, op: OP_RCP};
              state_d = T_RCP;
            end
          end else begin
            req_d = '{start: 1'b1, op: OP_MUL};
          end
        end
      end
      T_RCP: begin
        if (fpu_done) begin
          res_d   = fpu_res;
          state_d = T_FIN;
        end
      end
      T_FIN: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      req_q       <= '{start: 1'b0, op: OP_MUL};
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    acc_q      <= acc_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o    = (state_q == T_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_bits_o = out_data_q;

endmodule

/* hw/rtl/fip_checker.sv */
// ----------------------------------------------------------------------------
// fip_checker
// Port-level checks of the integer power block, bound to its top level.
// ----------------------------------------------------------------------------
`include "float_integer_power_top_assert.svh"

module fip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [63:0] base_bits_i,
  input logic signed [11:0] exponent_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] result_bits_o
);

  // A held result does not change until it is taken.
  `FIP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_bits_o))

  // One request at a time: the block is busy right after accepting one.
  `FIP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // Returning to idle always comes with a result on the output.
  `FIP_ASSERT_SAME(a_ready_with_result, $rose(in_ready_o), out_valid_o)

endmodule

bind float_integer_power_top fip_checker u_fip_checker (.*);
